FILE: rtl/rtbe_pkg.sv
// Shared types, constants and helper functions of the RTC time to BCD encoder.
`default_nettype none

package rtbe_pkg;

  // Pipeline stages: front checks, century product, weekday sum, output register
  localparam int NUM_STAGES = 4;

  localparam int YEAR_W  = 14;
  localparam int OFFSET_W = 7;
  localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 14'd2000;

  // Field limits
  localparam logic [5:0] MAX_SECOND = 6'd59;
  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [4:0] MIN_DAY    = 5'd1;
  localparam logic [4:0] MAX_DAY    = 5'd31;
  localparam logic [3:0] MIN_MONTH  = 4'd1;
  localparam logic [3:0] MAX_MONTH  = 4'd12;
  localparam logic [13:0] YEAR_SPAN = 14'd99;

  localparam logic [3:0] JANUARY  = 4'd1;
  localparam logic [3:0] FEBRUARY = 4'd2;

  // Tens-digit masks of the clock registers
  localparam logic [3:0] TENS_MASK_SEC   = 4'h7;
  localparam logic [3:0] TENS_MASK_MIN   = 4'h7;
  localparam logic [3:0] TENS_MASK_HOUR  = 4'h3;
  localparam logic [3:0] TENS_MASK_DAY   = 4'h3;
  localparam logic [3:0] TENS_MASK_MONTH = 4'h1;
  localparam logic [3:0] TENS_MASK_YEAR  = 4'hf;

  // floor(q/25) == (q * 5243) >> 17 for q < 4096
  localparam int QUARTER_W = YEAR_W - 2;
  localparam int CENT_PROD_W = 25;
  localparam int CENT_SHIFT = 17;
  localparam int CENTURY_W = CENT_PROD_W - CENT_SHIFT;
  localparam logic [CENT_PROD_W-1:0] CENTURY_RECIP = 25'd5243;

  // Weekday partial sum (always positive, below 2^15)
  localparam int SUM_W = 15;
  localparam logic [SUM_W-1:0] MINUS_ONE_MOD7 = 15'd6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

  typedef struct packed {
    logic                err;
    logic [5:0]          second;
    logic [5:0]          minute;
    logic [4:0]          hour;
    logic [4:0]          day;
    logic [3:0]          month;
    logic [OFFSET_W-1:0] offset;
    logic [YEAR_W-1:0]   year_adj;
    logic [2:0]          month_term;
    logic                prev_year_neg;
  } front_t;

  typedef struct packed {
    logic       error;
    logic [2:0] weekday;
    logic [7:0] second_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] day_bcd;
    logic [7:0] month_bcd;
    logic [7:0] weekday_byte;
    logic [7:0] year_bcd;
  } result_t;

  // (2m + 3(m+1)/5) mod 7, with Jan/Feb as months 13/14
  function automatic logic [2:0] month_term(input logic [3:0] month);
    logic [2:0] t;
    unique case (month)
      4'd1:    t = 3'd6;
      4'd2:    t = 3'd2;
      4'd3:    t = 3'd1;
      4'd4:    t = 3'd4;
      4'd5:    t = 3'd6;
      4'd6:    t = 3'd2;
      4'd7:    t = 3'd4;
      4'd8:    t = 3'd0;
      4'd9:    t = 3'd3;
      4'd10:   t = 3'd5;
      4'd11:   t = 3'd1;
      4'd12:   t = 3'd3;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  // v / 10 as (v * 205) >> 11, exact for v < 1029
  function automatic logic [7:0] bcd_byte(input logic [6:0] v, input logic [3:0] tens_mask);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens & tens_mask, units[3:0]};
  endfunction

  // mod 7 by folding octal digits (8 == 1 mod 7)
  function automatic logic [2:0] mod7(input logic [SUM_W-1:0] s);
    logic [5:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    f1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
    f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
    f3 = 4'(f2[2:0]) + 4'(f2[3]);
    return (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rtbe_if.sv
// Request channel interfaces: calendar time in, packed BCD clock registers out.
`default_nettype none

interface rtbe_time_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [13:0] full_year;

  modport source (output valid, second, minute, hour, day_of_month, month, full_year,
                  input ready);
  modport sink (input valid, second, minute, hour, day_of_month, month, full_year,
                output ready);
endinterface

interface rtbe_bcd_if;
  logic       valid;
  logic       ready;
  logic       error;
  logic [2:0] weekday;
  logic [7:0] second_bcd;
  logic [7:0] minute_bcd;
  logic [7:0] hour_bcd;
  logic [7:0] day_bcd;
  logic [7:0] month_bcd;
  logic [7:0] weekday_byte;
  logic [7:0] year_bcd;

  modport source (output valid, error, weekday, second_bcd, minute_bcd, hour_bcd,
                  day_bcd, month_bcd, weekday_byte, year_bcd,
                  input ready);
  modport sink (input valid, error, weekday, second_bcd, minute_bcd, hour_bcd,
                day_bcd, month_bcd, weekday_byte, year_bcd,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/rtbe_ctrl.sv
// Pipeline valid bits and per-stage advance chain (bubbles collapse).
`default_nettype none

module rtbe_ctrl
  import rtbe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       out_ready,
  output logic            in_ready,
  output pipe_ctrl_t      ctrl
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES:0]   adv;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_next[0] = adv[0] ? in_valid : vld[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_next[k] = adv[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready = adv[0];
  assign ctrl.en  = adv[NUM_STAGES-1:0];
  assign ctrl.vld = vld;

endmodule

`default_nettype wire

FILE: rtl/rtbe_front.sv
// First stage: range checks, year offset, month/year adjustment for the weekday.
`default_nettype none

module rtbe_front
  import rtbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [YEAR_W-1:0] base_year,
  input  wire logic [5:0]        second,
  input  wire logic [5:0]        minute,
  input  wire logic [4:0]        hour,
  input  wire logic [4:0]        day_of_month,
  input  wire logic [3:0]        month,
  input  wire logic [YEAR_W-1:0] full_year,
  output front_t                 front
);

  front_t           front_next;
  logic [YEAR_W:0]  offset_w;
  logic             year_bad;
  logic             jan_feb;

  always_comb begin
    offset_w = {1'b0, full_year} - {1'b0, base_year};
    year_bad = offset_w[YEAR_W] || (offset_w[YEAR_W-1:0] > YEAR_SPAN);
    jan_feb  = (month == JANUARY) || (month == FEBRUARY);

    front_next.err = (second > MAX_SECOND) || (minute > MAX_MINUTE) || (hour > MAX_HOUR) ||
                     (day_of_month < MIN_DAY) || (day_of_month > MAX_DAY) ||
                     (month < MIN_MONTH) || (month > MAX_MONTH) || year_bad;
    front_next.second     = second;
    front_next.minute     = minute;
    front_next.hour       = hour;
    front_next.day        = day_of_month;
    front_next.month      = month;
    front_next.offset     = offset_w[OFFSET_W-1:0];
    front_next.month_term = month_term(month);
    // Jan/Feb of year zero: previous year is -1, folded in later as +6 mod 7
    front_next.prev_year_neg = jan_feb && (full_year == '0);
    if (front_next.prev_year_neg) begin
      front_next.year_adj = '0;
    end else if (jan_feb) begin
      front_next.year_adj = full_year - YEAR_W'(1);
    end else begin
      front_next.year_adj = full_year;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rtbe_weekday.sv
// Weekday stages: century product, then the Gregorian sum; mod 7 after the sum register.
`default_nettype none

module rtbe_weekday
  import rtbe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   en_prod,
  input  wire logic   en_sum,
  input  wire front_t front,
  output logic [2:0]  weekday
);

  logic [QUARTER_W-1:0]   quarter;
  logic [CENT_PROD_W-1:0] cent_prod;
  logic [SUM_W-1:0]       year_sum;
  logic [4:0]             day_p;
  logic [2:0]             mterm_p;
  logic                   neg_p;
  logic [CENTURY_W-1:0]   century;
  logic [SUM_W-1:0]       total_next;
  logic [SUM_W-1:0]       total;

  assign quarter = front.year_adj[YEAR_W-1:2];

  always_ff @(posedge clk) begin
    if (en_prod) begin
      cent_prod <= CENT_PROD_W'(quarter) * CENTURY_RECIP;
      year_sum  <= SUM_W'(front.year_adj) + SUM_W'(quarter);
      day_p     <= front.day;
      mterm_p   <= front.month_term;
      neg_p     <= front.prev_year_neg;
    end
  end

  // y + y/4 - y/100 + y/400 + day + month term
  always_comb begin
    century    = cent_prod[CENT_PROD_W-1:CENT_SHIFT];
    total_next = year_sum - SUM_W'(century) + SUM_W'(century[CENTURY_W-1:2]) +
                 SUM_W'(day_p) + SUM_W'(mterm_p) + (neg_p ? MINUS_ONE_MOD7 : '0);
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      total <= total_next;
    end
  end

  assign weekday = mod7(total) + 3'd1;

endmodule

`default_nettype wire

FILE: rtl/rtbe_pack.sv
// BCD byte packing, carried alongside the weekday stages; output register with error zeroing.
`default_nettype none

module rtbe_pack
  import rtbe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en_prod,
  input  wire logic       en_sum,
  input  wire logic       en_out,
  input  wire front_t     front,
  input  wire logic [2:0] weekday,
  output result_t         result
);

  typedef struct packed {
    logic       err;
    logic [7:0] second_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] day_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
  } bytes_t;

  bytes_t bytes_next;
  bytes_t bytes_p;
  bytes_t bytes_s;
  result_t result_next;

  always_comb begin
    bytes_next.err        = front.err;
    bytes_next.second_bcd = bcd_byte(7'(front.second), TENS_MASK_SEC);
    bytes_next.minute_bcd = bcd_byte(7'(front.minute), TENS_MASK_MIN);
    bytes_next.hour_bcd   = bcd_byte(7'(front.hour), TENS_MASK_HOUR);
    bytes_next.day_bcd    = bcd_byte(7'(front.day), TENS_MASK_DAY);
    bytes_next.month_bcd  = bcd_byte(7'(front.month), TENS_MASK_MONTH);
    bytes_next.year_bcd   = bcd_byte(front.offset, TENS_MASK_YEAR);
  end

  always_comb begin
    if (bytes_s.err) begin
      result_next       = '0;
      result_next.error = 1'b1;
    end else begin
      result_next.error        = 1'b0;
      result_next.weekday      = weekday;
      result_next.second_bcd   = bytes_s.second_bcd;
      result_next.minute_bcd   = bytes_s.minute_bcd;
      result_next.hour_bcd     = bytes_s.hour_bcd;
      result_next.day_bcd      = bytes_s.day_bcd;
      result_next.month_bcd    = bytes_s.month_bcd;
      result_next.weekday_byte = {5'b0, weekday};
      result_next.year_bcd     = bytes_s.year_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      bytes_p <= bytes_next;
    end
    if (en_sum) begin
      bytes_s <= bytes_p;
    end
    if (en_out) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rtc_time_to_bcd_encoder.sv
// Each request is registered in turn by the front, product, sum and output stages.
// Throughput: one request per cycle unless stalled; each stage advances when empty or when
//   it drains, so a stalled output only blocks intake once all four stages hold requests.
// The depth is set by the y/100 reciprocal multiply and the weekday sum feeding mod 7.
// Reset (rst, synchronous, active high) empties the pipeline and sets base_year to 2000.
`default_nettype none

module rtc_time_to_bcd_encoder
  import rtbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [YEAR_W-1:0] cfg_wdata,
  rtbe_time_if.sink              time_chan,
  rtbe_bcd_if.source             reg_chan
);

  // Stage map: 0 front checks, 1 century product + BCD, 2 weekday sum, 3 output register
  localparam int ST_FRONT = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_OUT   = 3;

  logic [YEAR_W-1:0] base_year;
  pipe_ctrl_t        ctrl;
  front_t            front;
  logic [2:0]        weekday;
  result_t           result;

  // Base year register; the user must write it only while the block is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_YEAR_RESET;
    end else if (cfg_we) begin
      base_year <= cfg_wdata;
    end
  end

  rtbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (time_chan.valid),
    .out_ready (reg_chan.ready),
    .in_ready  (time_chan.ready),
    .ctrl      (ctrl)
  );

  // Range checks and year offset are settled in the first stage
  rtbe_front u_front (
    .clk          (clk),
    .en           (ctrl.en[ST_FRONT]),
    .base_year    (base_year),
    .second       (time_chan.second),
    .minute       (time_chan.minute),
    .hour         (time_chan.hour),
    .day_of_month (time_chan.day_of_month),
    .month        (time_chan.month),
    .full_year    (time_chan.full_year),
    .front        (front)
  );

  // Weekday: y/100 by reciprocal multiply, then the summed terms, mod 7 by digit folding
  rtbe_weekday u_weekday (
    .clk     (clk),
    .en_prod (ctrl.en[ST_PROD]),
    .en_sum  (ctrl.en[ST_SUM]),
    .front   (front),
    .weekday (weekday)
  );

  // BCD bytes travel in step with the weekday; error zeroes everything at the output
  rtbe_pack u_pack (
    .clk     (clk),
    .en_prod (ctrl.en[ST_PROD]),
    .en_sum  (ctrl.en[ST_SUM]),
    .en_out  (ctrl.en[ST_OUT]),
    .front   (front),
    .weekday (weekday),
    .result  (result)
  );

  assign reg_chan.valid        = ctrl.vld[ST_OUT];
  assign reg_chan.error        = result.error;
  assign reg_chan.weekday      = result.weekday;
  assign reg_chan.second_bcd   = result.second_bcd;
  assign reg_chan.minute_bcd   = result.minute_bcd;
  assign reg_chan.hour_bcd     = result.hour_bcd;
  assign reg_chan.day_bcd      = result.day_bcd;
  assign reg_chan.month_bcd    = result.month_bcd;
  assign reg_chan.weekday_byte = result.weekday_byte;
  assign reg_chan.year_bcd     = result.year_bcd;

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !reg_chan.valid)
    else $error("result valid right after reset");

  // An empty output register means every stage can move, so intake is open
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !reg_chan.valid |-> time_chan.ready)
    else $error("request stalled with empty output register");

  // A good result always carries a weekday 1..7
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    (reg_chan.valid && !reg_chan.error) |-> (reg_chan.weekday != 3'd0))
    else $error("weekday zero on a good result");

  // Error results carry all-zero bytes
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (reg_chan.valid && reg_chan.error) |->
      (reg_chan.weekday == 3'd0) && (reg_chan.second_bcd == 8'd0) &&
      (reg_chan.year_bcd == 8'd0) && (reg_chan.weekday_byte == 8'd0))
    else $error("error result with nonzero bytes");

endmodule

`default_nettype wire
